FILE: hw/rtl/sipa_pkg.sv
// ----------------------------------------------------------------------------
// sipa_pkg
// Shared widths, register indexes and types of the split image pixel
// address unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sipa_pkg;

  localparam int COORD_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int XW         = COORD_BITS + 1;
  localparam int PROD_W     = XW + COORD_BITS;
  localparam int POS_W      = PROD_W + 1;
  localparam int PPS_W      = 24;
  localparam int SEG_BITS   = 8;
  localparam int OUT_SEG_W  = 8;
  localparam int RW         = PPS_W + SEG_BITS;
  localparam int CMP_W      = ((POS_W > RW) ? POS_W : RW) + 1;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LWIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UWIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_USL    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PPS    = 3'd7;

  localparam int MODE_MIRROR_X = 0;
  localparam int MODE_MIRROR_Y = 1;
  localparam int MODE_SPLIT    = 2;

  // Rising edges from the accepting edge to the edge that takes the result
  localparam int LATENCY = 6 + SEG_BITS;

  typedef struct packed {
    logic          valid;
    logic          mapped;
    logic [RW-1:0] rem;
  } div_in_t;

  typedef struct packed {
    logic                valid;
    logic                mapped;
    logic [SEG_BITS-1:0] quot;
    logic [PPS_W-1:0]    rem;
  } div_out_t;

  function automatic logic [COORD_BITS-1:0] lo_coord(input logic [CFG_W-1:0] r);
    return r[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] hi_coord(input logic [CFG_W-1:0] r);
    return r[FIELD_W +: COORD_BITS];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/split_image_pixel_address_unit.sv
// ----------------------------------------------------------------------------
// split_image_pixel_address_unit
// Maps a view coordinate to a segment number and an offset in that segment.
// ----------------------------------------------------------------------------
// Throughput: one coordinate per cycle; busy stays low, and the 14-stage
// pipeline (5 address stages, 8 divider stages, result register) advances
// every cycle.
// Reset clears the pipeline valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module split_image_pixel_address_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [sipa_pkg::FIELD_W-1:0]   in_column,
  input  wire logic [sipa_pkg::FIELD_W-1:0]   in_line,
  output logic                                out_strobe,
  output logic                                out_inside_res,
  output logic [sipa_pkg::OUT_SEG_W-1:0]      out_segment_index,
  output logic [sipa_pkg::PPS_W-1:0]          out_segment_offset,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sipa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sipa_pkg::CFG_W-1:0]     cfg_data
);
  import sipa_pkg::*;

  // Configuration registers
  logic [2:0]       mode_r;
  logic [CFG_W-1:0] crop_r, vis_r, full_r, lwin_r, uwin_r;
  logic [15:0]      usl_r;
  logic [PPS_W-1:0] pps_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      crop_r <= '0;
      vis_r  <= '0;
      full_r <= '0;
      lwin_r <= '0;
      uwin_r <= '0;
      usl_r  <= '0;
      pps_r  <= PPS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE: mode_r <= cfg_data[2:0];
        REG_CROP: crop_r <= cfg_data;
        REG_VIS:  vis_r  <= cfg_data;
        REG_FULL: full_r <= cfg_data;
        REG_LWIN: lwin_r <= cfg_data;
        REG_UWIN: uwin_r <= cfg_data;
        REG_USL:  usl_r  <= cfg_data[15:0];
        REG_PPS:  pps_r  <= cfg_data[PPS_W-1:0];
      endcase
    end
  end

  logic [COORD_BITS-1:0] full_cols, full_lines, up_east;
  assign full_cols  = lo_coord(full_r);
  assign full_lines = hi_coord(full_r);
  assign up_east    = lo_coord(uwin_r);

  // Stage 1: view check and crop shift
  logic          s1_v_r, s1_out_r;
  logic [XW-1:0] s1_x_r, s1_y_r;
  logic [COORD_BITS-1:0] in_x, in_y;
  assign in_x = in_column[COORD_BITS-1:0];
  assign in_y = in_line[COORD_BITS-1:0];

  // Stage 2: mirroring
  logic          s2_v_r, s2_out_r;
  logic [XW-1:0] s2_x_r, s2_y_r;
  logic          s2_out_nxt;
  logic [XW-1:0] s2_x_nxt, s2_y_nxt;

  always_comb begin
    s2_out_nxt = s1_out_r;
    s2_x_nxt   = s1_x_r;
    s2_y_nxt   = s1_y_r;
    if (mode_r[MODE_MIRROR_X]) begin
      if (s1_x_r >= XW'(full_cols)) s2_out_nxt = 1'b1;
      s2_x_nxt = XW'(full_cols) - s1_x_r - XW'(1);
    end
    if (mode_r[MODE_MIRROR_Y]) begin
      if (s1_y_r >= XW'(full_lines)) s2_out_nxt = 1'b1;
      s2_y_nxt = XW'(full_lines) - s1_y_r - XW'(1);
    end
  end

  // Stage 3: split window selection and stride
  logic                  s3_v_r, s3_out_r;
  logic [XW-1:0]         s3_x_r, s3_y_r;
  logic [COORD_BITS-1:0] s3_stride_r;
  logic                  s3_out_nxt, upper;
  logic [XW-1:0]         s3_x_nxt;
  logic [COORD_BITS-1:0] s3_stride_nxt, east, west, usl;

  assign usl   = usl_r[COORD_BITS-1:0];
  assign upper = (usl != '0) && (s2_y_r >= (XW'(usl) - XW'(1)));
  assign east  = upper ? up_east : lo_coord(lwin_r);
  assign west  = upper ? hi_coord(uwin_r) : hi_coord(lwin_r);

  always_comb begin
    s3_out_nxt    = s2_out_r;
    s3_x_nxt      = s2_x_r;
    s3_stride_nxt = full_cols;
    if (mode_r[MODE_SPLIT]) begin
      if (s2_x_r < XW'(east) || s2_x_r > XW'(west)) s3_out_nxt = 1'b1;
      if (full_cols <= up_east) s3_out_nxt = 1'b1;
      s3_x_nxt      = s2_x_r - XW'(east);
      s3_stride_nxt = full_cols - up_east - COORD_BITS'(1);
    end
  end

  // Stage 4: row multiply
  logic              s4_v_r, s4_out_r;
  logic [XW-1:0]     s4_x_r;
  logic [PROD_W-1:0] s4_prod_r;

  // Stage 5: linear position and range check
  logic             s5_v_r, s5_in_r;
  logic [RW-1:0]    s5_rem_r;
  logic [POS_W-1:0] pos;
  logic             ovf;
  assign pos = POS_W'(s4_prod_r) + POS_W'(s4_x_r);
  assign ovf = CMP_W'(pos) >= (CMP_W'(pps_r) << SEG_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      s1_v_r <= start && !busy;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_out_r    <= (in_x >= lo_coord(vis_r)) || (in_y >= hi_coord(vis_r));
    s1_x_r      <= XW'(in_x) + XW'(lo_coord(crop_r));
    s1_y_r      <= XW'(in_y) + XW'(hi_coord(crop_r));
    s2_out_r    <= s2_out_nxt;
    s2_x_r      <= s2_x_nxt;
    s2_y_r      <= s2_y_nxt;
    s3_out_r    <= s3_out_nxt;
    s3_x_r      <= s3_x_nxt;
    s3_y_r      <= s2_y_r;
    s3_stride_r <= s3_stride_nxt;
    s4_out_r    <= s3_out_r;
    s4_x_r      <= s3_x_r;
    s4_prod_r   <= PROD_W'(s3_y_r) * PROD_W'(s3_stride_r);
    s5_in_r     <= !(s4_out_r || ovf || (pps_r == '0));
    s5_rem_r    <= RW'(pos);
  end

  // Segment division
  div_in_t  div_in;
  div_out_t div_out;
  assign div_in.valid  = s5_v_r;
  assign div_in.mapped = s5_in_r;
  assign div_in.rem    = s5_rem_r;

  sipa_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .pps   (pps_r),
    .din   (div_in),
    .dout  (div_out)
  );

  // Result register
  logic                 out_strobe_r, out_inside_r;
  logic [OUT_SEG_W-1:0] out_index_r;
  logic [PPS_W-1:0]     out_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= div_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_inside_r <= div_out.mapped;
    out_index_r  <= div_out.mapped ? OUT_SEG_W'(div_out.quot) : '0;
    out_offset_r <= div_out.mapped ? div_out.rem : '0;
  end

  assign out_strobe         = out_strobe_r;
  assign out_inside_res     = out_inside_r;
  assign out_segment_index  = out_index_r;
  assign out_segment_offset = out_offset_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sipa_divider.sv
// ----------------------------------------------------------------------------
// sipa_divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sipa_divider (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [sipa_pkg::PPS_W-1:0] pps,
  input  wire sipa_pkg::div_in_t          din,
  output sipa_pkg::div_out_t              dout
);
  import sipa_pkg::*;

  logic                v_r   [SEG_BITS+1];
  logic                ins_r [SEG_BITS+1];
  logic [RW-1:0]       rem_r [SEG_BITS+1];
  logic [SEG_BITS-1:0] q_r   [SEG_BITS+1];

  assign v_r[0]   = din.valid;
  assign ins_r[0] = din.mapped;
  assign rem_r[0] = din.rem;
  assign q_r[0]   = '0;

  for (genvar i = 0; i < SEG_BITS; i++) begin : g_stage
    localparam int K = SEG_BITS - 1 - i;
    logic [RW-1:0] dsh;
    logic          ge;

    assign dsh = RW'(pps) << K;
    assign ge  = rem_r[i] >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      ins_r[i+1]    <= ins_r[i];
      rem_r[i+1]    <= ge ? (rem_r[i] - dsh) : rem_r[i];
      q_r[i+1]      <= q_r[i] | (SEG_BITS'(ge) << K);
    end
  end

  assign dout.valid  = v_r[SEG_BITS];
  assign dout.mapped = ins_r[SEG_BITS];
  assign dout.quot   = q_r[SEG_BITS];
  assign dout.rem    = rem_r[SEG_BITS][PPS_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/sipa_checker.sv
// ----------------------------------------------------------------------------
// sipa_checker
// Port-level checks of the split image pixel address unit.
// ----------------------------------------------------------------------------
`default_nettype none

module sipa_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           out_strobe,
  input wire logic                           out_inside_res,
  input wire logic [sipa_pkg::OUT_SEG_W-1:0] out_segment_index,
  input wire logic [sipa_pkg::PPS_W-1:0]     out_segment_offset,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready
);
  import sipa_pkg::*;

  logic accept;
  assign accept = start && !busy;

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LATENCY))
    else $error("result without a matching input transfer");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept ##LATENCY 1'b1 |-> out_strobe)
    else $error("input transfer produced no result");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_inside_res) |->
      (out_segment_index == '0) && (out_segment_offset == '0))
    else $error("outside result carries a nonzero address");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration transfer held off");

endmodule

bind split_image_pixel_address_unit sipa_checker u_sipa_checker (.*);

`default_nettype wire
